// ----- rtl/core/u8u16_pkg.sv -----
// ---------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 stream decoder: the
// controller/datapath command and status groups and the code point limits.
// ---------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

   // Input operation codes
   localparam logic OP_DECODE  = 1'b0;
   localparam logic OP_DISCARD = 1'b1;

   // Code point limits and UTF-16 building blocks
   localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [20:0] SURR_LO     = 21'h00D800;
   localparam logic [20:0] SURR_HI     = 21'h00DFFF;
   localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
   localparam logic [20:0] PAIR_OFFSET = 21'h010000;
   localparam logic [20:0] MIN_LEN2    = 21'h000080;
   localparam logic [20:0] MIN_LEN3    = 21'h000800;
   localparam logic [15:0] HIGH_BASE   = 16'hD800;
   localparam logic [15:0] LOW_BASE    = 16'hDC00;

   // Byte buffer: up to three held bytes plus the new one
   localparam int BUF_DEPTH = 4;

   // Controller to datapath commands
   typedef struct packed {
      logic append;     // write the accepted byte behind the held bytes
      logic clear;      // discard the held bytes
      logic advance;    // take the decoded unit into the pending slot
      logic push;       // move the pending unit to the output register
      logic last;       // mark the pushed unit as the last of its run
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic       stop;        // no further unit can be decoded from the buffer
      logic       pend_valid;  // a decoded unit waits in the pending slot
      logic       out_free;    // the output register can take a unit now
      logic [2:0] count;       // bytes in the buffer
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/u8u16_if.sv -----
// ---------------------------------------------------------------------------
// u8u16_req_if / u8u16_rsp_if
// Valid/ready channels of the decoder: byte requests in, code units out.
// ---------------------------------------------------------------------------
`default_nettype none

interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        is_replacement;
   logic        last_of_run;

   modport source (output valid, output code_unit, output is_replacement,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_unit, input is_replacement,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/u8u16_ctrl.sv -----
// ---------------------------------------------------------------------------
// u8u16_ctrl
// Sequencer: accepts one request; discard clears the buffer, decode steps it
// one code unit per cycle while the output is free, until nothing decodes.
// ---------------------------------------------------------------------------
`default_nettype none

module u8u16_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_op,
   output logic                       req_ready,
   input  wire u8u16_pkg::status_type status,
   output u8u16_pkg::cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == u8u16_pkg::OP_DISCARD) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.append = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.stop) begin
               // Flush the held unit as the last one of the run
               if (!status.pend_valid) begin
                  state_in = ST_IDLE;
               end else if (status.out_free) begin
                  cmd.push = 1'b1;
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (!status.pend_valid || status.out_free) begin
               // Take the next unit; release the previous one as not last
               cmd.advance = 1'b1;
               cmd.push    = status.pend_valid;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/u8u16_dp.sv -----
// ---------------------------------------------------------------------------
// u8u16_dp
// Datapath of the decoder: byte buffer, sequence decoder and checker,
// surrogate pair split, pending unit slot and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module u8u16_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire u8u16_pkg::cmd_type    cmd,
   input  wire logic [7:0]            data_byte,
   output u8u16_pkg::status_type      status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [15:0]                rsp_code_unit,
   output logic                       rsp_is_replacement,
   output logic                       rsp_last_of_run
);

   logic [7:0]  buf_ff [u8u16_pkg::BUF_DEPTH];
   logic [7:0]  buf_in [u8u16_pkg::BUF_DEPTH];
   logic [2:0]  count_ff, count_in;
   logic        half_ff, half_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [15:0] pend_unit_ff;
   logic        pend_repl_ff;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_unit_ff;
   logic        out_repl_ff;
   logic        out_last_ff;

   logic [2:0]  seq_len;
   logic        stray;
   logic        cont_ok;
   logic        bad;
   logic [20:0] cp;
   logic [20:0] pair_val;
   logic        stop;
   logic [15:0] unit;
   logic        repl;
   logic        pair;
   logic [2:0]  drop;
   logic        out_free;

   // Classify the lead byte
   always_comb begin
      stray   = 1'b0;
      seq_len = 3'd1;
      if (!buf_ff[0][7]) begin
         seq_len = 3'd1;
      end else if (buf_ff[0][7:5] == 3'b110) begin
         seq_len = 3'd2;
      end else if (buf_ff[0][7:4] == 4'b1110) begin
         seq_len = 3'd3;
      end else if (buf_ff[0][7:3] == 5'b11110) begin
         seq_len = 3'd4;
      end else begin
         stray = 1'b1;
      end
   end

   // Assemble and check the code point
   always_comb begin
      cont_ok = 1'b1;
      bad     = 1'b0;
      cp      = {13'd0, buf_ff[0]};
      case (seq_len)
         3'd1: begin
            cp = {13'd0, buf_ff[0]};
         end
         3'd2: begin
            cont_ok = (buf_ff[1][7:6] == 2'b10);
            cp      = {10'd0, buf_ff[0][4:0], buf_ff[1][5:0]};
            bad     = (cp < u8u16_pkg::MIN_LEN2);
         end
         3'd3: begin
            cont_ok = (buf_ff[1][7:6] == 2'b10) && (buf_ff[2][7:6] == 2'b10);
            cp      = {5'd0, buf_ff[0][3:0], buf_ff[1][5:0], buf_ff[2][5:0]};
            bad     = (cp < u8u16_pkg::MIN_LEN3) ||
                      ((cp >= u8u16_pkg::SURR_LO) && (cp <= u8u16_pkg::SURR_HI));
         end
         3'd4: begin
            cont_ok = (buf_ff[1][7:6] == 2'b10) && (buf_ff[2][7:6] == 2'b10) &&
                      (buf_ff[3][7:6] == 2'b10);
            cp      = {buf_ff[0][2:0], buf_ff[1][5:0], buf_ff[2][5:0],
                       buf_ff[3][5:0]};
            bad     = (cp < u8u16_pkg::PAIR_OFFSET) || (cp > u8u16_pkg::CP_MAX);
         end
         default: begin
            cont_ok = 1'b0;
         end
      endcase
   end

   assign pair_val = cp - u8u16_pkg::PAIR_OFFSET;

   // Pick the unit to emit and how many bytes it consumes
   always_comb begin
      stop = (count_ff == 3'd0) || (!stray && (seq_len > count_ff));
      pair = 1'b0;
      repl = 1'b0;
      unit = cp[15:0];
      drop = seq_len;
      if (stray || !cont_ok || bad) begin
         unit = u8u16_pkg::REPL_CHAR;
         repl = 1'b1;
         drop = 3'd1;
      end else if (cp > u8u16_pkg::BMP_MAX) begin
         // High half first with the bytes kept, low half consumes them
         pair = 1'b1;
         if (half_ff) begin
            unit = u8u16_pkg::LOW_BASE + {6'd0, pair_val[9:0]};
            drop = 3'd4;
         end else begin
            unit = u8u16_pkg::HIGH_BASE + {6'd0, pair_val[19:10]};
            drop = 3'd0;
         end
      end
   end

   // Buffer update: append, discard or shift out consumed bytes
   always_comb begin
      for (int k = 0; k < u8u16_pkg::BUF_DEPTH; k++) begin
         buf_in[k] = buf_ff[k];
      end
      count_in = count_ff;
      half_in  = half_ff;
      if (cmd.clear) begin
         count_in = 3'd0;
      end
      if (cmd.append) begin
         for (int k = 0; k < u8u16_pkg::BUF_DEPTH; k++) begin
            if (count_ff == 3'(k)) begin
               buf_in[k] = data_byte;
            end
         end
         count_in = count_ff + 3'd1;
      end
      if (cmd.advance) begin
         case (drop)
            3'd1: begin
               buf_in[0] = buf_ff[1];
               buf_in[1] = buf_ff[2];
               buf_in[2] = buf_ff[3];
            end
            3'd2: begin
               buf_in[0] = buf_ff[2];
               buf_in[1] = buf_ff[3];
            end
            3'd3: begin
               buf_in[0] = buf_ff[3];
            end
            default: begin
            end
         endcase
         count_in = count_ff - drop;
         if (pair) begin
            half_in = !half_ff;
         end
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;

   // Pending slot and output register occupancy
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.advance) begin
         pend_valid_in = 1'b1;
      end else if (cmd.push) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (cmd.push) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= 3'd0;
         half_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         half_ff       <= half_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < u8u16_pkg::BUF_DEPTH; k++) begin
         buf_ff[k] <= buf_in[k];
      end
      if (cmd.push) begin
         out_unit_ff <= pend_unit_ff;
         out_repl_ff <= pend_repl_ff;
         out_last_ff <= cmd.last;
      end
      if (cmd.advance) begin
         pend_unit_ff <= unit;
         pend_repl_ff <= repl;
      end
   end

   assign status.stop       = stop;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;
   assign status.count      = count_ff;

   assign rsp_valid          = out_valid_ff;
   assign rsp_code_unit      = out_unit_ff;
   assign rsp_is_replacement = out_repl_ff;
   assign rsp_last_of_run    = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/utf8_to_utf16_stream_decoder_core.sv -----
// ---------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_core
// UTF-8 byte stream in, UTF-16 code units out, with U+FFFD for bad input.
//
// req_ch carries one transaction per byte: op selects decode of data_byte
// or discard of the held incomplete bytes. rsp_ch carries the code units a
// byte produces (0 to 4), the last one flagged with last_of_run; a unit of
// U+FFFD that stands for a malformed byte has is_replacement set.
// A decode transaction is accepted and then scanned: one scan step per unit
// through the shared sequence decoder, and a final scan step that finds
// nothing more and flushes the last unit. A discard transaction clears the
// held bytes on acceptance. The block takes one transaction at a time;
// req_ch.ready is high only between transactions.
// The first unit goes through the pending slot and the output register to rsp_ch.
// Reset empties the held bytes and drops any unit not yet delivered.
// When the receiver stalls, the output register holds its unit and one more
// unit waits in the pending slot; decoding halts until the output frees.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_stream_decoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   u8u16_req_if.sink       req_ch,
   u8u16_rsp_if.source     rsp_ch
);

   u8u16_pkg::cmd_type    cmd;
   u8u16_pkg::status_type status;

   u8u16_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   u8u16_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .data_byte          (req_ch.data_byte),
      .status             (status),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_code_unit      (rsp_ch.code_unit),
      .rsp_is_replacement (rsp_ch.is_replacement),
      .rsp_last_of_run    (rsp_ch.last_of_run)
   );

   // A new transaction never starts while a unit of the last one is pending
   a_accept_no_pending: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> !status.pend_valid)
      else $error("request accepted with a unit still pending");

   // Between transactions the buffer holds at most three bytes
   a_held_limit: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> (status.count <= 3'd3))
      else $error("held byte count above three");

   // A unit is only moved out when the output register can take it
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> status.out_free)
      else $error("unit pushed over an undelivered one");

   // After a last unit is pushed the block returns to accepting requests
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && cmd.last) |=> req_ch.ready)
      else $error("run did not end after its last unit");

endmodule

`default_nettype wire
